>>> sv/a85sd_pkg.sv
// Package for the ascii85 stream decoder: word types, result codes,
// character constants and the base-85 place values. No dependencies.
`default_nettype none

package a85sd_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] error_code;
        logic       last;
    } t_out;

    typedef enum logic [3:0] {
        PH_SEEK  = 4'b0001,
        PH_LT    = 4'b0010,
        PH_BODY  = 4'b0100,
        PH_TILDE = 4'b1000
    } t_phase;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] ERR_NO_START = 2'd0;
    localparam logic [1:0] ERR_TILDE    = 2'd1;
    localparam logic [1:0] ERR_NO_END   = 2'd2;
    localparam logic [1:0] ERR_INVALID  = 2'd3;

    localparam logic CFG_USE_DELIM = 1'b0;
    localparam logic CFG_SKIP_INV  = 1'b1;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_Z     = 8'h7a;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam logic [31:0] SPACES4 = 32'h20202020;

    // place value of digit k within a group, most significant digit first
    function automatic logic [31:0] f_pow85(input logic [2:0] k);
        logic [31:0] v;
        case (k)
            3'd0:    v = 32'd52200625;
            3'd1:    v = 32'd614125;
            3'd2:    v = 32'd7225;
            3'd3:    v = 32'd85;
            default: v = 32'd1;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/ascii85_stream_decoder_unit.sv
// Top level of the ascii85 stream decoder: input skid register, decode
// step and a four-word result buffer. Depends on a85sd_pkg.
`default_nettype none

// Usage:
//   Input channel  (i_in_valid / i_in_data / o_in_stall) carries one text
//   byte or an end-of-input marker per word. Output channel (o_out_valid /
//   o_out_data / i_out_stall) carries data bytes, end and error words; the
//   last word caused by an input word has last set.
//   Config: i_cfg_we with i_cfg_idx (0 use_delimiters, 1 skip_invalid) and
//   i_cfg_data, written while the block is idle.
//   Order: an accepted word is held in the input register; the decode step
//   writes its results into the result buffer, which presents the first.
//   Throughput: one input word per cycle while each word makes at most one
//   result and the output is not stalled. A word making more than one result
//   (group of five digits, 'z', 'y', or a final partial group) holds the next
//   word until the buffer, drained one word per cycle, is down to its last.
//   Reset: config returns to use_delimiters=1, skip_invalid=0, decoder
//   hunts for "<~", buffers empty.
//   Stall: a stalled output word holds; the input register takes one more
//   word and then the input stalls until the buffer drains.

module ascii85_stream_decoder_unit
    import a85sd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_idx,
    input  wire logic i_cfg_data,
    input  wire logic i_in_valid,
    input  wire t_in  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out      o_out_data,
    input  wire logic i_out_stall
);

    logic        r_use_delim;
    logic        r_skip_inv;

    logic        r_in_v;
    t_in         r_in;

    t_phase      r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_dc, n_dc;

    t_out        r_res [4];
    t_out        n_res [4];
    logic [2:0]  r_left, n_cnt;
    logic [1:0]  r_rd;

    logic        proc;
    logic        out_acc;

    assign out_acc     = o_out_valid && !i_out_stall;
    assign proc        = r_in_v && (r_left == 3'd0 || (r_left == 3'd1 && !i_out_stall));
    assign o_in_stall  = r_in_v && !proc;
    assign o_out_valid = (r_left != 3'd0);
    assign o_out_data  = r_res[r_rd];

    function automatic t_out f_word(input logic [1:0] kind, input logic [7:0] data,
                                    input logic [1:0] err);
        t_out w;
        w.kind       = kind;
        w.data_byte  = data;
        w.error_code = err;
        w.last       = 1'b0;
        return w;
    endfunction

    always_comb begin
        logic [7:0]  c;
        logic        eoi;
        logic        ws;
        logic        restart;
        logic [7:0]  digit;
        logic [31:0] acc_sum;
        logic [31:0] acc_fin;
        logic [2:0]  nb;
        t_phase      rst_phase;

        c         = r_in.text_byte;
        eoi       = r_in.end_of_input;
        ws        = !eoi && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
        restart   = 1'b0;
        digit     = c - CH_BANG;
        acc_sum   = r_acc + 32'(32'(digit) * f_pow85(r_dc));
        acc_fin   = r_acc + f_pow85(r_dc - 3'd1);
        nb        = (r_dc == 3'd0) ? 3'd0 : r_dc - 3'd1;
        rst_phase = r_use_delim ? PH_SEEK : PH_BODY;

        n_phase = r_phase;
        n_acc   = r_acc;
        n_dc    = r_dc;
        n_cnt   = 3'd0;
        for (int i = 0; i < 4; i++) begin
            n_res[i] = '0;
        end

        if (!ws) begin
            unique case (r_phase)
                PH_SEEK, PH_LT: begin
                    if (eoi) begin
                        n_res[0] = f_word(KIND_ERR, 8'd0, ERR_NO_START);
                        n_cnt    = 3'd1;
                        restart  = 1'b1;
                    end else if (r_phase == PH_LT && c == CH_TILDE) begin
                        n_phase = PH_BODY;
                    end else begin
                        n_phase = (c == CH_LT) ? PH_LT : PH_SEEK;
                    end
                end
                PH_TILDE: begin
                    restart = 1'b1;
                    if (!eoi && c == CH_GT) begin
                        for (int i = 0; i < 3; i++) begin
                            if (3'(i) < nb) begin
                                n_res[i] = f_word(KIND_DATA, acc_fin[31-8*i -: 8], 2'd0);
                            end
                        end
                        n_res[nb[1:0]] = f_word(KIND_END, 8'd0, 2'd0);
                        n_cnt          = nb + 3'd1;
                    end else begin
                        n_res[0] = f_word(KIND_ERR, 8'd0, ERR_TILDE);
                        n_cnt    = 3'd1;
                    end
                end
                PH_BODY: begin
                    if (eoi) begin
                        restart = 1'b1;
                        if (r_use_delim) begin
                            n_res[0] = f_word(KIND_ERR, 8'd0, ERR_NO_END);
                            n_cnt    = 3'd1;
                        end else begin
                            // final partial group, rounded up
                            for (int i = 0; i < 3; i++) begin
                                if (3'(i) < nb) begin
                                    n_res[i] = f_word(KIND_DATA, acc_fin[31-8*i -: 8], 2'd0);
                                end
                            end
                            n_res[nb[1:0]] = f_word(KIND_END, 8'd0, 2'd0);
                            n_cnt          = nb + 3'd1;
                        end
                    end else if (c == CH_Z && r_dc == 3'd0) begin
                        for (int i = 0; i < 4; i++) begin
                            n_res[i] = f_word(KIND_DATA, 8'd0, 2'd0);
                        end
                        n_cnt = 3'd4;
                    end else if (c == CH_Y && r_dc == 3'd0) begin
                        for (int i = 0; i < 4; i++) begin
                            n_res[i] = f_word(KIND_DATA, SPACES4[31-8*i -: 8], 2'd0);
                        end
                        n_cnt = 3'd4;
                    end else if (c == CH_TILDE && r_use_delim) begin
                        n_phase = PH_TILDE;
                    end else if (c < CH_BANG || c > CH_U) begin
                        if (!r_skip_inv) begin
                            n_res[0] = f_word(KIND_ERR, 8'd0, ERR_INVALID);
                            n_cnt    = 3'd1;
                            restart  = 1'b1;
                        end
                    end else if (r_dc == 3'd4) begin
                        for (int i = 0; i < 4; i++) begin
                            n_res[i] = f_word(KIND_DATA, acc_sum[31-8*i -: 8], 2'd0);
                        end
                        n_cnt = 3'd4;
                        n_acc = 32'd0;
                        n_dc  = 3'd0;
                    end else begin
                        n_acc = acc_sum;
                        n_dc  = r_dc + 3'd1;
                    end
                end
                default: begin
                    restart = 1'b1;
                end
            endcase
        end

        if (restart) begin
            n_phase = rst_phase;
            n_acc   = 32'd0;
            n_dc    = 3'd0;
        end

        for (int i = 0; i < 4; i++) begin
            n_res[i].last = (3'(i) == n_cnt - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_delim <= 1'b1;
            r_skip_inv  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_USE_DELIM) begin
                r_use_delim <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_SKIP_INV) begin
                r_skip_inv <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_acc   <= 32'd0;
            r_dc    <= 3'd0;
        end else if (proc) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_dc    <= n_dc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_rd   <= 2'd0;
        end else if (proc) begin
            r_left <= n_cnt;
            r_rd   <= 2'd0;
        end else if (out_acc) begin
            r_left <= r_left - 3'd1;
            r_rd   <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            for (int i = 0; i < 4; i++) begin
                r_res[i] <= n_res[i];
            end
        end
    end

    // checks
    a_left_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'd4)
        else $error("result buffer count above four");

    a_dc_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dc <= 3'd4)
        else $error("digit count above four");

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (r_left == 3'd1)))
        else $error("last flag out of step with buffer count");

    a_proc_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |-> (r_left == 3'd0 || (r_left == 3'd1 && out_acc)))
        else $error("decode step overwrote pending results");

endmodule

`default_nettype wire
